// ===== hw/rtl/sorted_integer_set_top_assert.svh =====
// Assertion macros for the sorted integer set.
`ifndef SORTED_INTEGER_SET_TOP_ASSERT_SVH
`define SORTED_INTEGER_SET_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define SIS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SIS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SIS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SIS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== hw/rtl/sis_pkg.sv =====
package sis_pkg;

	localparam int CAPACITY = 16;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int KIND_W   = 2;
	localparam int INDEX_W  = 4;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;
	localparam int ELEM_W   = 32;

	typedef logic signed [ELEM_W-1:0] elem_t;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT   = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_READ_OK  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_BEYOND   = 3'd6;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		elem_t              value;
		logic [INDEX_W-1:0] index;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		elem_t               element;
	} res_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		elem_t             data;
	} mem_wr_t;

endpackage

// ===== hw/rtl/sis_mem.sv =====
module sis_mem (
	input  logic                       clk,
	input  sis_pkg::mem_wr_t           wr,
	input  logic [sis_pkg::ADDR_W-1:0] raddr,
	output sis_pkg::elem_t             rdata
);

	sis_pkg::elem_t mem [sis_pkg::CAPACITY];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/sis_seq.sv =====
`include "sorted_integer_set_top_assert.svh"

module sis_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  sis_pkg::cmd_t              cmd,
	output logic                       busy,
	output logic                       done,
	output sis_pkg::res_t              result,
	output sis_pkg::mem_wr_t           wr,
	output logic [sis_pkg::ADDR_W-1:0] raddr,
	input  sis_pkg::elem_t             rdata
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_INS  = 3'd2;
	localparam logic [2:0] S_REM  = 3'd3;
	localparam logic [2:0] S_READ = 3'd4;

	logic [2:0]                state_q, state_d;
	sis_pkg::cmd_t             cmd_q, cmd_d;
	logic [sis_pkg::CNT_W-1:0] pos_q, pos_d;
	logic [sis_pkg::CNT_W-1:0] cnt_q, cnt_d;
	sis_pkg::elem_t            carry_q, carry_d;
	logic                      done_q, done_d;
	sis_pkg::res_t             res_q, res_d;

	logic [sis_pkg::CNT_W-1:0] pos_inc;
	logic                      at_end;
	logic                      full;
	logic                      eq;
	logic                      gt;

	assign pos_inc = pos_q + 1'b1;
	assign at_end  = (pos_q == cnt_q);
	assign full    = (cnt_q == sis_pkg::CNT_W'(sis_pkg::CAPACITY));
	assign eq      = (rdata == cmd_q.value);
	assign gt      = (rdata > cmd_q.value);

	always_comb begin
		state_d        = state_q;
		cmd_d          = cmd_q;
		pos_d          = pos_q;
		cnt_d          = cnt_q;
		carry_d        = carry_q;
		done_d         = 1'b0;
		res_d.status   = sis_pkg::ST_BEYOND;
		res_d.element  = '0;
		wr.en          = 1'b0;
		wr.addr        = pos_q[sis_pkg::ADDR_W-1:0];
		wr.data        = carry_q;
		raddr          = pos_inc[sis_pkg::ADDR_W-1:0];

		unique case (state_q)
			S_IDLE: begin
				raddr = (cmd.kind == sis_pkg::KIND_READ) ?
					sis_pkg::ADDR_W'(cmd.index) : '0;
				if (start) begin
					cmd_d = cmd;
					pos_d = '0;
					if (cmd.kind == sis_pkg::KIND_INSERT ||
						cmd.kind == sis_pkg::KIND_REMOVE) begin
						state_d = S_SCAN;
					end else if (cmd.kind == sis_pkg::KIND_READ &&
						sis_pkg::CNT_W'(cmd.index) < cnt_q) begin
						state_d = S_READ;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			S_SCAN: begin
				if (at_end) begin
					done_d  = 1'b1;
					state_d = S_IDLE;
					if (cmd_q.kind == sis_pkg::KIND_INSERT) begin
						if (full) begin
							res_d.status = sis_pkg::ST_FULL;
						end else begin
							wr.en        = 1'b1;
							wr.data      = cmd_q.value;
							cnt_d        = cnt_q + 1'b1;
							res_d.status = sis_pkg::ST_INSERTED;
						end
					end else begin
						res_d.status = sis_pkg::ST_ABSENT;
					end
				end else if (cmd_q.kind == sis_pkg::KIND_INSERT) begin
					if (eq) begin
						done_d       = 1'b1;
						state_d      = S_IDLE;
						res_d.status = sis_pkg::ST_PRESENT;
					end else if (gt) begin
						if (full) begin
							done_d       = 1'b1;
							state_d      = S_IDLE;
							res_d.status = sis_pkg::ST_FULL;
						end else begin
							wr.en   = 1'b1;
							wr.data = cmd_q.value;
							carry_d = rdata;
							pos_d   = pos_inc;
							state_d = S_INS;
						end
					end else begin
						pos_d = pos_inc;
					end
				end else begin
					if (eq) begin
						pos_d   = pos_inc;
						state_d = S_REM;
					end else if (gt) begin
						done_d       = 1'b1;
						state_d      = S_IDLE;
						res_d.status = sis_pkg::ST_ABSENT;
					end else begin
						pos_d = pos_inc;
					end
				end
			end
			S_INS: begin
				wr.en = 1'b1;
				if (at_end) begin
					cnt_d        = cnt_q + 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
					res_d.status = sis_pkg::ST_INSERTED;
				end else begin
					carry_d = rdata;
					pos_d   = pos_inc;
				end
			end
			S_REM: begin
				if (at_end) begin
					cnt_d        = cnt_q - 1'b1;
					done_d       = 1'b1;
					state_d      = S_IDLE;
					res_d.status = sis_pkg::ST_REMOVED;
				end else begin
					wr.en   = 1'b1;
					wr.addr = sis_pkg::ADDR_W'(pos_q - 1'b1);
					wr.data = rdata;
					pos_d   = pos_inc;
				end
			end
			S_READ: begin
				done_d        = 1'b1;
				state_d       = S_IDLE;
				res_d.status  = sis_pkg::ST_READ_OK;
				res_d.element = rdata;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		res_d.count = sis_pkg::COUNT_W'(cnt_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		pos_q   <= pos_d;
		carry_q <= carry_d;
		res_q   <= res_d;
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = res_q;

	`SIS_ASSERT_NEVER(a_cnt_max, clk, arst_n, cnt_q > sis_pkg::CNT_W'(sis_pkg::CAPACITY), "count above capacity")
	`SIS_ASSERT(a_done_idle, clk, arst_n, done_q |-> state_q == S_IDLE, "result while still busy")
	`SIS_ASSERT(a_cnt_on_done, clk, arst_n, cnt_q != $past(cnt_q) |-> done_q, "count moved without a result")
	`SIS_ASSERT_NEVER(a_wr_state, clk, arst_n, wr.en && (state_q == S_IDLE || state_q == S_READ), "store written outside scan or shift")

endmodule

// ===== hw/rtl/sorted_integer_set_top.sv =====
// Sorted integer set: holds up to 16 distinct signed 32-bit values in ascending
// order. Pulse start with a command while busy is low; one transaction per
// command comes back on result, marked by done for exactly one cycle, and there
// is no way to hold it off, so capture it whenever done is high. A read within
// the count passes through a read state first; a read beyond it, or an unknown
// command code, is answered straight from idle. Insert and remove walk the
// store (one write port, one read port) one entry per cycle; busy stays high
// meanwhile. A new command may be started in the cycle in which done is high.
module sorted_integer_set_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  sis_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done,
	output sis_pkg::res_t result
);

	sis_pkg::mem_wr_t           wr;
	logic [sis_pkg::ADDR_W-1:0] raddr;
	sis_pkg::elem_t             rdata;

	sis_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result),
		.wr     (wr),
		.raddr  (raddr),
		.rdata  (rdata)
	);

	sis_mem u_mem (
		.clk   (clk),
		.wr    (wr),
		.raddr (raddr),
		.rdata (rdata)
	);

endmodule

// ===== bench/sorted_integer_set_top_tb.sv =====
`timescale 1ns / 1ps

module sorted_integer_set_top_tb;
	import sis_pkg::*;

	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
	localparam elem_t VAL_MIN = 32'sh8000_0000;
	localparam elem_t VAL_MAX = 32'sh7FFF_FFFF;
	localparam int RANDOM_CMDS = 1420;
	localparam int POOL_SIZE = 24;
	localparam int STALL_LIMIT = 4000;
	localparam int CALM_FIRST = 600;
	localparam int CALM_LAST = 900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic done;
	res_t result;

	cmd_t pending_cmds[$];
	res_t expected_results[$];
	elem_t set_vals[CAPACITY];
	int unsigned set_count = 0;
	int unsigned cmds_accepted = 0;
	int unsigned mismatches = 0;
	int unsigned stall_cycles = 0;
	elem_t pool[POOL_SIZE];

	sorted_integer_set_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.done(done),
		.result(result)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic res_t apply_cmd(cmd_t c);
		res_t r;
		int unsigned pos;
		int unsigned k;
		r = '0;
		pos = 0;
		while (pos < set_count && set_vals[pos] != c.value)
			pos++;
		case (c.kind)
			KIND_INSERT: begin
				if (pos < set_count) begin
					r.status = ST_PRESENT;
				end else if (set_count >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					k = set_count;
					while (k > 0 && set_vals[k-1] > c.value) begin
						set_vals[k] = set_vals[k-1];
						k--;
					end
					set_vals[k] = c.value;
					set_count++;
					r.status = ST_INSERTED;
				end
			end
			KIND_REMOVE: begin
				if (pos >= set_count) begin
					r.status = ST_ABSENT;
				end else begin
					for (k = pos; k + 1 < set_count; k++)
						set_vals[k] = set_vals[k+1];
					set_count--;
					r.status = ST_REMOVED;
				end
			end
			KIND_READ: begin
				if (c.index < set_count) begin
					r.status = ST_READ_OK;
					r.element = set_vals[c.index];
				end else begin
					r.status = ST_BEYOND;
				end
			end
			default: begin
				r.status = ST_BEYOND;
			end
		endcase
		r.count = set_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic add_cmd(logic [KIND_W-1:0] kind, elem_t value, logic [INDEX_W-1:0] index);
		cmd_t c;
		c.kind = kind;
		c.value = value;
		c.index = index;
		pending_cmds.push_back(c);
	endtask

	task automatic refresh_pool();
		for (int i = 0; i < POOL_SIZE; i++) begin
			case ($urandom_range(3))
				0: pool[i] = elem_t'($urandom_range(40)) - 20;
				1: pool[i] = (i % 2) ? VAL_MAX - elem_t'($urandom_range(3)) :
					VAL_MIN + elem_t'($urandom_range(3));
				default: pool[i] = elem_t'($urandom);
			endcase
		end
	endtask

	task automatic add_random_cmds();
		int w;
		bit filling;
		elem_t v;
		filling = 1'b1;
		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 120 == 0) begin
				refresh_pool();
				filling = !filling || n == 0;
			end
			w = $urandom_range(99);
			v = ($urandom_range(9) == 0) ? elem_t'($urandom) :
				pool[$urandom_range(POOL_SIZE-1)];
			if (w < (filling ? 60 : 25))
				add_cmd(KIND_INSERT, v, 4'($urandom));
			else if (w < 80)
				add_cmd(KIND_REMOVE, v, 4'($urandom));
			else if (w < 98)
				add_cmd(KIND_READ, elem_t'($urandom), 4'($urandom));
			else
				add_cmd(KIND_SPARE, elem_t'($urandom), 4'($urandom));
		end
	endtask

	// hold a transaction until accepted, then advance or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd <= '0;
		end else begin
			if (start && !busy) begin
				expected_results.push_back(apply_cmd(cmd));
				cmds_accepted++;
			end
			if (!start || !busy) begin
				if (pending_cmds.size() > 0 && ((cmds_accepted >= CALM_FIRST &&
						cmds_accepted < CALM_LAST) || $urandom_range(99) >= 21)) begin
					start <= 1'b1;
					cmd <= pending_cmds.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		res_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d count %0d element %0d",
						result.status, result.count, result.element);
			end else begin
				exp_r = expected_results.pop_front();
				if (result.status !== exp_r.status || result.count !== exp_r.count ||
						result.element !== exp_r.element) begin
					mismatches++;
					if (mismatches <= 10) begin
						$write("mismatch: expected status %0d count %0d element %0d, ",
							exp_r.status, exp_r.count, exp_r.element);
						$display("got status %0d count %0d element %0d",
							result.status, result.count, result.element);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("sorted_integer_set_top_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		add_cmd(KIND_READ, 0, 4'd0);
		add_cmd(KIND_REMOVE, 5, 4'd0);
		add_cmd(KIND_SPARE, VAL_MAX, 4'hF);
		add_cmd(KIND_INSERT, VAL_MAX, 4'hF);
		add_cmd(KIND_INSERT, VAL_MIN, 4'd0);
		add_cmd(KIND_INSERT, 0, 4'd0);
		add_cmd(KIND_INSERT, 0, 4'd0);
		add_cmd(KIND_READ, VAL_MIN, 4'd0);
		add_cmd(KIND_READ, VAL_MAX, 4'd2);
		add_cmd(KIND_READ, 0, 4'd3);
		for (int v = -6; v <= 6; v++)
			if (v != 0)
				add_cmd(KIND_INSERT, elem_t'(v), 4'd0);
		add_cmd(KIND_INSERT, -32'sd1000, 4'd0);
		add_cmd(KIND_INSERT, 32'sd1000, 4'd0);
		add_cmd(KIND_INSERT, VAL_MIN, 4'd0);
		add_cmd(KIND_READ, 0, 4'hF);
		add_cmd(KIND_REMOVE, 0, 4'hF);
		add_cmd(KIND_REMOVE, 0, 4'd0);
		add_random_cmds();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("sorted_integer_set_top_tb OK");
		else
			$display("sorted_integer_set_top_tb NOT OK");
		$finish;
	end

endmodule
